[hdl/ldwf_pkg.sv]
// Shared types and constants for the pipelined long divider.
`timescale 1ns / 1ps

package ldwf_pkg;

    // Operand word width and the number of restoring steps in the cell chain.
    localparam int DATA_W    = 32;
    localparam int NUM_STEPS = DATA_W;

    // Stream payload widths.
    localparam int S_TDATA_W = 3 * DATA_W;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 72;

    // One item in flight along the divider chain.
    typedef struct packed {
        logic              valid;
        logic              is_signed;
        logic              div_zero;
        logic              ovf;        // quotient magnitude needs more than 32 bits
        logic              aneg;       // dividend is negative (remainder sign)
        logic              qneg;       // quotient is negative
        logic [DATA_W-1:0] dmag;       // divisor magnitude
        logic [DATA_W-1:0] rem;        // partial remainder
        logic [DATA_W-1:0] shift;      // dividend bits in, quotient bits out
    } ldwf_work_t;

    // One finished result beat.
    typedef struct packed {
        logic [DATA_W-1:0] quotient;
        logic [DATA_W-1:0] remainder;
        logic              write_back;
        logic              overflow_flag;
        logic              negative_flag;
        logic              zero_flag;
        logic              divide_by_zero;
    } ldwf_result_t;

endpackage

[hdl/ldwf_prep.sv]
// Input cell: forms operand magnitudes, signs and the early overflow check.
`timescale 1ns / 1ps

module ldwf_prep
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [ldwf_pkg::DATA_W-1:0]   dividend_low,
    input  logic [ldwf_pkg::DATA_W-1:0]   dividend_high,
    input  logic [ldwf_pkg::DATA_W-1:0]   divisor,
    input  logic                          is_signed,
    input  logic                          long_dividend,
    output ldwf_pkg::ldwf_work_t          work
);
    import ldwf_pkg::*;

    logic [2*DATA_W-1:0] dividend;
    logic [2*DATA_W-1:0] amag;
    logic [DATA_W-1:0]   dmag;
    logic                aneg;
    logic                dneg;
    logic                ovf;
    ldwf_work_t          work_reg;
    ldwf_work_t          work_next;

    // Build the 64-bit dividend: high word, sign extension or zero extension.
    always_comb
    begin
        if (long_dividend)
        begin
            dividend = {dividend_high, dividend_low};
        end
        else if (is_signed)
        begin
            dividend = {{DATA_W{dividend_low[DATA_W-1]}}, dividend_low};
        end
        else
        begin
            dividend = {{DATA_W{1'b0}}, dividend_low};
        end
    end

    // Magnitudes of both operands.
    assign aneg = is_signed & dividend[2*DATA_W-1];
    assign dneg = is_signed & divisor[DATA_W-1];
    assign amag = aneg ? (~dividend + 1'b1) : dividend;
    assign dmag = dneg ? (~divisor + 1'b1) : divisor;

    // The quotient fits 32 bits only when the upper half is below the divisor.
    assign ovf = (amag[2*DATA_W-1:DATA_W] >= dmag);

    always_comb
    begin
        work_next.valid     = in_valid;
        work_next.is_signed = is_signed;
        work_next.div_zero  = (divisor == '0);
        work_next.ovf       = ovf;
        work_next.aneg      = aneg;
        work_next.qneg      = aneg ^ dneg;
        work_next.dmag      = dmag;
        // An overflowing item starts from zero so the chain invariant holds.
        work_next.rem       = ovf ? '0 : amag[2*DATA_W-1:DATA_W];
        work_next.shift     = amag[DATA_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_reg <= '0;
        end
        else if (en)
        begin
            work_reg <= work_next;
        end
    end

    assign work = work_reg;

endmodule

[hdl/ldwf_cell.sv]
// Divider cell: one restoring step that yields one quotient bit per item.
`timescale 1ns / 1ps

module ldwf_cell
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  ldwf_pkg::ldwf_work_t work_in,
    output ldwf_pkg::ldwf_work_t work_out
);
    import ldwf_pkg::*;

    logic [DATA_W:0]   trial;
    logic [DATA_W+1:0] diff;
    logic              q_bit;
    ldwf_work_t        work_reg;
    ldwf_work_t        work_next;

    // Bring down the next dividend bit and try subtracting the divisor.
    assign trial = {work_in.rem, work_in.shift[DATA_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, work_in.dmag};
    assign q_bit = ~diff[DATA_W+1];

    always_comb
    begin
        work_next       = work_in;
        work_next.rem   = q_bit ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
        work_next.shift = {work_in.shift[DATA_W-2:0], q_bit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_reg <= '0;
        end
        else if (en)
        begin
            work_reg <= work_next;
        end
    end

    assign work_out = work_reg;

endmodule

[hdl/ldwf_post.sv]
// Output cell logic: signed range check, sign fix-up and condition flags.
`timescale 1ns / 1ps

module ldwf_post
(
    input  ldwf_pkg::ldwf_work_t   work,
    output ldwf_pkg::ldwf_result_t result
);
    import ldwf_pkg::*;

    localparam logic [DATA_W-1:0] MIN_NEG_MAG = {1'b1, {(DATA_W-1){1'b0}}};

    logic              range_ovf;
    logic [DATA_W-1:0] q_fix;
    logic [DATA_W-1:0] r_fix;

    // Signed results must fit the two's complement range of a word.
    always_comb
    begin
        if (!work.is_signed)
        begin
            range_ovf = 1'b0;
        end
        else if (work.qneg)
        begin
            range_ovf = (work.shift > MIN_NEG_MAG);
        end
        else
        begin
            range_ovf = work.shift[DATA_W-1];
        end
    end

    assign q_fix = work.qneg ? (~work.shift + 1'b1) : work.shift;
    assign r_fix = work.aneg ? (~work.rem + 1'b1) : work.rem;

    // Divide by zero wins, then overflow, then the normal result.
    always_comb
    begin
        result = '0;
        if (work.div_zero)
        begin
            result.divide_by_zero = 1'b1;
        end
        else if (work.ovf || range_ovf)
        begin
            result.overflow_flag = 1'b1;
            result.negative_flag = 1'b1;
        end
        else
        begin
            result.quotient      = q_fix;
            result.remainder     = r_fix;
            result.write_back    = 1'b1;
            result.negative_flag = q_fix[DATA_W-1];
            result.zero_flag     = (q_fix == '0);
        end
    end

endmodule

[hdl/long_divide_with_flags.sv]
// Top level: pipelined 64-by-32 long divider with condition flags.
//
// Input stream (s_*): one beat per divide. s_tdata carries the low dividend
// word, the high dividend word and the divisor; s_tuser carries the mode bits
// (signed, 64-bit dividend). Output stream (m_*): one beat per input beat, in
// order, with quotient, remainder and the flags write_back, V, N, Z and
// divide-by-zero. The carry flag is always clear and is not carried.
//
// An accepted input beat passes the input cell register, one register per
// quotient bit in the chain of 32 divider cells, and the output register.
// The chain accepts a new beat every cycle while s_tready is high, so the
// throughput is one divide per clock when the receiver does not stall.
//
// When the receiver stalls, a finished result waits in the output register
// and the next one lands in a skid register; only then does the whole chain
// freeze and s_tready drop, so s_tready never depends combinationally on
// m_tready. Reset clears every valid bit; no result is pending afterward.
`timescale 1ns / 1ps

module long_divide_with_flags
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // dividend_low, dividend_high, divisor
    input  logic [ldwf_pkg::S_TDATA_W-1:0]    s_tdata,
    // is_signed, long_dividend
    input  logic [ldwf_pkg::S_TUSER_W-1:0]    s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // quotient, remainder, write_back, overflow_flag, negative_flag,
    // zero_flag, divide_by_zero, zero padding
    output logic [ldwf_pkg::M_TDATA_W-1:0]    m_tdata
);
    import ldwf_pkg::*;

    localparam int RES_W = $bits(ldwf_result_t);

    logic         en;
    ldwf_work_t   chain [0:NUM_STEPS];
    ldwf_result_t post_result;
    logic         new_valid;
    logic         take;

    ldwf_result_t out_reg;
    ldwf_result_t out_next;
    logic         out_valid_reg;
    logic         out_valid_next;
    ldwf_result_t skid_reg;
    ldwf_result_t skid_next;
    logic         skid_valid_reg;
    logic         skid_valid_next;

    // The chain moves whenever the skid register is free.
    assign en       = ~skid_valid_reg;
    assign s_tready = en;

    ldwf_prep u_prep
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_valid      (s_tvalid),
        .dividend_low  (s_tdata[DATA_W-1:0]),
        .dividend_high (s_tdata[2*DATA_W-1:DATA_W]),
        .divisor       (s_tdata[3*DATA_W-1:2*DATA_W]),
        .is_signed     (s_tuser[0]),
        .long_dividend (s_tuser[1]),
        .work          (chain[0])
    );

    // Chain of restoring divider cells, one quotient bit each.
    for (genvar i = 0; i < NUM_STEPS; i++)
    begin : g_cell
        ldwf_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .work_in  (chain[i]),
            .work_out (chain[i+1])
        );
    end

    ldwf_post u_post
    (
        .work   (chain[NUM_STEPS]),
        .result (post_result)
    );

    // A result leaves the chain only in a cycle in which the chain moves.
    assign new_valid = chain[NUM_STEPS].valid & en;
    assign take      = out_valid_reg & m_tready;

    // Output register with skid register behind it.
    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || take)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_next       = post_result;
                out_valid_next = new_valid;
            end
        end
        else if (new_valid)
        begin
            skid_next       = post_result;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    // Pack the result fields from the lowest bit up, zero padded.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-RES_W){1'b0}},
                       out_reg.divide_by_zero,
                       out_reg.zero_flag,
                       out_reg.negative_flag,
                       out_reg.overflow_flag,
                       out_reg.write_back,
                       out_reg.remainder,
                       out_reg.quotient};

    // The skid register is only ever filled behind a full output register.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a result while the output is empty");

    // A full skid register stays full until the receiver takes a beat.
    a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !m_tready) |=> skid_valid_reg)
        else $error("skid register dropped a result during a stall");

    // The chain end does not move while the input side is held off.
    a_chain_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |=> $stable(chain[NUM_STEPS]))
        else $error("divider chain advanced while stalled");

    // A divide by zero carries no quotient and no write back.
    a_dz_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.divide_by_zero) |->
            (!out_reg.write_back && !out_reg.overflow_flag && out_reg.quotient == '0))
        else $error("divide by zero result carries other data");

    // Overflow and write back never come together.
    a_wb_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.write_back) |->
            (!out_reg.overflow_flag && !out_reg.divide_by_zero))
        else $error("write back raised together with overflow");

endmodule
